// File: sv/fdq15_pkg.sv
// Shared constants and widths for the decimating Q15 FIR filter.
package fdq15_pkg;

    // Storage sizes
    localparam int MAX_TAPS       = 64;
    localparam int MAX_DECIMATION = 16;

    // Derived widths
    localparam int TAP_IDX_W = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
    localparam int PHASE_W   = $clog2(MAX_DECIMATION);

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int ACC_W     = 32;
    localparam int OPCODE_W  = 2;
    localparam int CIDX_W    = 6;
    localparam int TAPCFG_W  = 7;
    localparam int DECCFG_W  = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECIMATION = 2'd1;

    // Reset values of the registers
    localparam logic [TAPCFG_W-1:0] TAP_COUNT_RST  = 7'd64;
    localparam logic [DECCFG_W-1:0] DECIMATION_RST = 5'd1;

    // Item kinds carried in tuser
    localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_COEF  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // Rounding offset: one half in Q15
    localparam logic [ACC_W-1:0] ACC_INIT = 32'd16384;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

// File: sv/fir_decimator_q15_core.sv
// Decimating Q15 FIR filter: one shared multiply-accumulate unit under a small sequencer.
// Items that produce no result (coefficient load, clear, non-final push) stay in idle, so
// the input is ready again in the next cycle. A push that completes a decimation phase
// runs the single MAC, one tap per cycle; input is not ready until its result is offered.
// The result waits in an output register, so the next item is accepted while it is pending.
// rst_n is asynchronous, active low: clears sequencer, history valid bits, ring position,
// phase and registers (tap_count 64, decimation_factor 1); coefficients stay unknown.
module fir_decimator_q15_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fdq15_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fdq15_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] sample, [21:16] coef_index, [37:22] coef_value, [39:38] zero
    input  logic [fdq15_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] opcode
    input  logic [fdq15_pkg::OPCODE_W-1:0]     s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] out_sample
    output logic [fdq15_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import fdq15_pkg::*;

    // Unpacked input fields
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [CIDX_W-1:0]          in_coef_index;
    logic signed [COEF_W-1:0]   in_coef_value;

    // Configuration registers
    logic [TAPCFG_W-1:0] tap_count_reg;
    logic [DECCFG_W-1:0] decimation_reg;
    logic [TAP_CNT_W-1:0] taps_use;
    logic [DECCFG_W-1:0]  factor_use;

    // Sequencer and ring state
    state_t state_reg, state_next;
    logic [TAP_IDX_W-1:0] wpos_reg, wpos_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [TAP_IDX_W-1:0] k_reg, k_next;
    logic [TAP_IDX_W-1:0] pos_reg, pos_next;
    logic [TAP_IDX_W-1:0] last_reg, last_next;
    logic [MAX_TAPS-1:0]  hist_valid_reg, hist_valid_next;
    logic                 rd_live_reg, rd_live_next;
    logic                 mul_live_reg, mul_live_next;
    logic                 out_valid_reg, out_valid_next;

    // Datapath registers
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [M_TDATA_W-1:0]       out_data_reg, out_data_next;
    logic signed [COEF_W-1:0]   coef_rd_reg;
    logic signed [SAMPLE_W-1:0] hist_rd_reg;
    logic                       hist_live_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic signed [SAMPLE_W-1:0] hist_use;

    // Ring arithmetic for a push
    logic [TAP_IDX_W-1:0] slot;
    logic [TAP_CNT_W-1:0] slot_inc;
    logic [DECCFG_W-1:0]  phase_inc;
    logic                 hist_we;
    logic                 coef_we;

    // Memories
    logic [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic [COEF_W-1:0]   coef_mem [MAX_TAPS];

    assign in_sample     = s_axis_tdata[SAMPLE_W-1:0];
    assign in_coef_index = s_axis_tdata[SAMPLE_W+CIDX_W-1:SAMPLE_W];
    assign in_coef_value = s_axis_tdata[SAMPLE_W+CIDX_W+COEF_W-1:SAMPLE_W+CIDX_W];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Clamp the configured tap count and decimation factor to their usable range
    always_comb
    begin
        if (tap_count_reg == '0)
            taps_use = TAP_CNT_W'(1);
        else if (TAP_CNT_W'(tap_count_reg) > TAP_CNT_W'(MAX_TAPS))
            taps_use = TAP_CNT_W'(MAX_TAPS);
        else
            taps_use = TAP_CNT_W'(tap_count_reg);

        if (decimation_reg == '0)
            factor_use = DECCFG_W'(1);
        else if (decimation_reg > DECCFG_W'(MAX_DECIMATION))
            factor_use = DECCFG_W'(MAX_DECIMATION);
        else
            factor_use = decimation_reg;
    end

    // Slot for the incoming sample, next ring position and phase
    assign slot      = ({1'b0, wpos_reg} < taps_use) ? wpos_reg : '0;
    assign slot_inc  = {1'b0, slot} + TAP_CNT_W'(1);
    assign phase_inc = DECCFG_W'(phase_reg) + DECCFG_W'(1);

    // Treat history entries not written since the last clear as zero
    assign hist_use = hist_live_reg ? hist_rd_reg : '0;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        wpos_next       = wpos_reg;
        phase_next      = phase_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        last_next       = last_reg;
        hist_valid_next = hist_valid_reg;
        rd_live_next    = 1'b0;
        mul_live_next   = rd_live_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hist_we         = 1'b0;
        coef_we         = 1'b0;

        // Accumulate whatever product leaves the multiplier, wrapping at 32 bits
        acc_next = mul_live_reg ? (acc_reg + ACC_W'(prod_reg)) : acc_reg;

        // Drop the result once its transfer completes
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        OP_PUSH:
                        begin
                            hist_we               = 1'b1;
                            hist_valid_next[slot] = 1'b1;
                            wpos_next = (slot_inc >= taps_use) ? '0
                                                               : slot_inc[TAP_IDX_W-1:0];
                            if (phase_inc >= factor_use)
                            begin
                                phase_next = '0;
                                acc_next   = ACC_INIT;
                                k_next     = '0;
                                pos_next   = slot;
                                last_next  = TAP_IDX_W'(taps_use - TAP_CNT_W'(1));
                                state_next = ST_MAC;
                            end
                            else
                            begin
                                phase_next = phase_inc[PHASE_W-1:0];
                            end
                        end
                        OP_COEF:
                        begin
                            coef_we = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            hist_valid_next = '0;
                            wpos_next       = '0;
                            phase_next      = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                // Issue one tap read per cycle, walking back through the ring
                rd_live_next = 1'b1;
                k_next       = k_reg + TAP_IDX_W'(1);
                pos_next     = (pos_reg == '0) ? last_reg : pos_reg - TAP_IDX_W'(1);
                if (k_reg == last_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // Hold until the MAC pipeline empties and the output register is free
                if (!rd_live_reg && !mul_live_reg && (!out_valid_reg || m_axis_tready))
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg[30:15];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wpos_reg       <= '0;
            phase_reg      <= '0;
            k_reg          <= '0;
            pos_reg        <= '0;
            last_reg       <= '0;
            hist_valid_reg <= '0;
            rd_live_reg    <= 1'b0;
            mul_live_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tap_count_reg  <= TAP_COUNT_RST;
            decimation_reg <= DECIMATION_RST;
        end
        else
        begin
            state_reg      <= state_next;
            wpos_reg       <= wpos_next;
            phase_reg      <= phase_next;
            k_reg          <= k_next;
            pos_reg        <= pos_next;
            last_reg       <= last_next;
            hist_valid_reg <= hist_valid_next;
            rd_live_reg    <= rd_live_next;
            mul_live_reg   <= mul_live_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TAP_COUNT:  tap_count_reg  <= cfg_data[TAPCFG_W-1:0];
                    CFG_DECIMATION: decimation_reg <= cfg_data[DECCFG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers: accumulator, output data, multiplier stage
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        out_data_reg  <= out_data_next;
        prod_reg      <= ACC_W'(coef_rd_reg * hist_use);
        hist_live_reg <= hist_valid_reg[pos_reg];
    end

    // History and coefficient memories with registered reads
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[slot] <= in_sample;
        if (coef_we)
            coef_mem[in_coef_index] <= in_coef_value;
        hist_rd_reg <= hist_mem[pos_reg];
        coef_rd_reg <= coef_mem[k_reg];
    end

endmodule

// File: sv/fdq15_checker.sv
// Port-level checker for the decimating Q15 FIR filter, bound to the top level.
module fdq15_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [fdq15_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input logic [fdq15_pkg::CFG_DATA_W-1:0]   cfg_data,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [fdq15_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input logic [fdq15_pkg::OPCODE_W-1:0]     s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [fdq15_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import fdq15_pkg::*;

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // A pending result holds its value until the transfer completes
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output result changed or vanished while stalled");

    // Items other than a push leave the input ready again in the next cycle
    a_quick_items: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_axis_tuser != OP_PUSH) |=> s_axis_tready)
        else $error("non-push item did not complete in one cycle");

    // Items other than a push never cause a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (s_axis_tuser != OP_PUSH) |=> !$rose(m_axis_tvalid))
        else $error("result appeared after a non-push item");

    // A new result appears only as the sequencer returns to accepting input
    a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
        else $error("result appeared outside the end of a convolution");

    // Configuration writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind fir_decimator_q15_core fdq15_checker u_fdq15_checker (.*);

// File: test/testbench.sv
// Self-checking stream testbench for the decimating Q15 FIR filter core.
`timescale 1ns / 100ps

module testbench;
    import fdq15_pkg::*;

    // Opcode and register indexes that the block leaves unused
    localparam logic [OPCODE_W-1:0]    OP_SPARE       = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

    // Settling wait, with margin over the longest push that completes a phase
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] sample, [21:16] coef_index, [37:22] coef_value, [39:38] zero
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    // [1:0] opcode
    logic [OPCODE_W-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] out_sample
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    // Predicted filter state
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
    int unsigned                wr_pos;
    int unsigned                phase_cnt;
    logic [TAPCFG_W-1:0]        tap_count_reg;
    logic [DECCFG_W-1:0]        decim_reg;

    logic [M_TDATA_W-1:0] expected_samples [$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    logic rx_hold = 1'b0;
    event hold_start;

    fir_decimator_q15_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fir_decimator_q15_core test failed");
            $finish;
        end
    end

    // Drive output back-pressure; the hold-off forces a long stall
    always @(negedge clk)
    begin
        m_axis_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end

    // Count out the hold-off stretch
    initial
    begin
        forever
        begin
            @(hold_start);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Compare each output transfer with the oldest predicted sample
    always @(posedge clk)
    begin
        logic [M_TDATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch($sformatf("unexpected out_sample %0d",
                                          $signed(m_axis_tdata)));
            else
            begin
                want = expected_samples.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch($sformatf("out_sample %0d, predicted %0d",
                                              $signed(m_axis_tdata), $signed(want)));
            end
        end
    end

    function automatic int unsigned taps_in_force();
        if (tap_count_reg == 0)
            return 1;
        if (tap_count_reg > MAX_TAPS)
            return MAX_TAPS;
        return tap_count_reg;
    endfunction

    function automatic int unsigned decim_in_force();
        if (decim_reg == 0)
            return 1;
        if (decim_reg > MAX_DECIMATION)
            return MAX_DECIMATION;
        return decim_reg;
    endfunction

    // Advance the filter prediction by one accepted item
    task automatic compute_filter_item(input logic [OPCODE_W-1:0] op,
                                       input logic [SAMPLE_W-1:0] sample,
                                       input logic [CIDX_W-1:0]   cidx,
                                       input logic [COEF_W-1:0]   cval);
        int unsigned         taps;
        int unsigned         slot;
        int unsigned         pos;
        logic signed [31:0]  prod;
        logic [ACC_W-1:0]    acc;
        taps = taps_in_force();
        case (op)
            OP_PUSH:
            begin
                slot = (wr_pos < taps) ? wr_pos : 0;
                hist_mem[slot] = sample;
                wr_pos = (slot + 1 >= taps) ? 0 : slot + 1;
                if (phase_cnt + 1 >= decim_in_force())
                begin
                    phase_cnt = 0;
                    acc = ACC_INIT;
                    pos = slot;
                    for (int k = 0; k < taps; k++)
                    begin
                        prod = coef_mem[k] * hist_mem[pos];
                        acc = acc + prod;
                        pos = (pos == 0) ? taps - 1 : pos - 1;
                    end
                    expected_samples.push_back(acc[30:15]);
                end
                else
                    phase_cnt++;
            end
            OP_COEF:
                coef_mem[cidx] = cval;
            OP_CLEAR:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = '0;
                wr_pos = 0;
                phase_cnt = 0;
            end
            default: ;
        endcase
    endtask

    // Offer one item on the input stream and hold it until the transfer
    task automatic offer_item(input logic [OPCODE_W-1:0] op,
                              input logic [SAMPLE_W-1:0] sample,
                              input logic [CIDX_W-1:0]   cidx,
                              input logic [COEF_W-1:0]   cval);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, cval, cidx, sample};
        do
            @(posedge clk);
        while (!s_axis_tready);
        compute_filter_item(op, sample, cidx, cval);
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] sample);
        offer_item(OP_PUSH, sample, CIDX_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic load_coef(input logic [CIDX_W-1:0] cidx, input logic [COEF_W-1:0] cval);
        offer_item(OP_COEF, SAMPLE_W'($urandom), cidx, cval);
    endtask

    task automatic send_control(input logic [OPCODE_W-1:0] op);
        offer_item(op, SAMPLE_W'($urandom), CIDX_W'($urandom), COEF_W'($urandom));
    endtask

    // Drop the input, collect every predicted sample, let the core settle
    task automatic wait_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TAP_COUNT:  tap_count_reg = data;
            CFG_DECIMATION: decim_reg = data[DECCFG_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] taps_data,
                             input logic [CFG_DATA_W-1:0] decim_data);
        wait_quiet();
        write_reg(CFG_TAP_COUNT, taps_data);
        write_reg(CFG_DECIMATION, decim_data);
    endtask

    // Mostly random words, with the two extremes mixed in
    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Load every tap, so no convolution reads an unwritten coefficient
    task automatic test_coef_load();
        load_coef(CIDX_W'(0), 16'h7fff);
        load_coef(CIDX_W'(1), 16'h8000);
        for (int i = 2; i < MAX_TAPS; i++)
            load_coef(CIDX_W'(i), rand_word());
    endtask

    // Registers still at reset: 64 taps, every push gives an output
    task automatic test_reset_defaults();
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'hffff);
        push_sample(16'h0000);
        push_sample(16'h0001);
        push_sample(16'h5555);
        push_sample(16'haaaa);
    endtask

    // Accumulator and final narrowing wrap
    task automatic test_wrap();
        configure(7'd2, 7'd1);
        load_coef(CIDX_W'(0), 16'h8000);
        load_coef(CIDX_W'(1), 16'h8000);
        push_sample(16'h8000);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        load_coef(CIDX_W'(0), 16'h7fff);
        load_coef(CIDX_W'(1), 16'h7fff);
        push_sample(16'h7fff);
        push_sample(16'h7fff);
        push_sample(16'h8000);
    endtask

    // Spare opcode, clear and coefficient load in the middle of a stream
    task automatic test_opcodes();
        configure(7'd3, 7'd2);
        push_sample(16'h1234);
        push_sample(16'hc000);
        send_control(OP_SPARE);
        push_sample(16'h4000);
        send_control(OP_CLEAR);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        load_coef(CIDX_W'(1), 16'h2000);
        push_sample(16'h0100);
        push_sample(16'hff00);
    endtask

    // Out-of-range register values, unmapped indexes, shrinking ring and phase
    task automatic test_reconfig_edges();
        configure(7'd0, 7'd0);
        push_sample(16'h3000);
        push_sample(16'hd000);
        wait_quiet();
        write_reg(CFG_UNMAPPED_2, 7'h7f);
        write_reg(CFG_UNMAPPED_3, 7'h55);
        configure(7'd127, 7'h7f);
        for (int i = 0; i < 6; i++)
            push_sample(rand_word());
        // Position and phase now lie past the smaller ring and factor
        configure(7'd4, 7'd3);
        push_sample(rand_word());
        push_sample(rand_word());
        push_sample(rand_word());
        push_sample(rand_word());
        configure(7'd64, 7'd16);
        for (int i = 0; i < 16; i++)
            push_sample(rand_word());
    endtask

    // Stall the output long enough for the core to stop taking input
    task automatic test_backpressure();
        configure(7'd4, 7'd1);
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_start;
        for (int i = 0; i < 24; i++)
            push_sample(rand_word());
        wait_quiet();
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_taps_data();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return CFG_DATA_W'($urandom_range(1, 8));
        if (r < 75)
            return CFG_DATA_W'($urandom_range(9, 63));
        if (r < 85)
            return CFG_DATA_W'(64);
        if (r < 93)
            return CFG_DATA_W'($urandom_range(65, 127));
        return '0;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_decim_data();
        if ($urandom_range(99) < 85)
            return {2'($urandom_range(3)), 5'($urandom_range(1, MAX_DECIMATION))};
        return CFG_DATA_W'($urandom_range(127));
    endfunction

    // Random segments, each under a fresh setting of both registers
    task automatic test_random_traffic(input int idle, input int stall, input int n_items);
        int sent;
        int seg_len;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            configure(rand_taps_data(), rand_decim_data());
            idle_pct  = idle;
            stall_pct = stall;
            seg_len = $urandom_range(30, 80);
            for (int i = 0; i < seg_len && sent < n_items; i++)
            begin
                r = $urandom_range(99);
                if (r < 86)
                    push_sample(rand_word());
                else if (r < 94)
                    load_coef(CIDX_W'($urandom), rand_word());
                else if (r < 97)
                    send_control(OP_CLEAR);
                else
                    send_control(OP_SPARE);
                sent++;
            end
        end
        wait_quiet();
    endtask

    initial
    begin
        // Reset state of the prediction
        foreach (hist_mem[i])
        begin
            hist_mem[i] = '0;
            coef_mem[i] = '0;
        end
        wr_pos        = 0;
        phase_cnt     = 0;
        tap_count_reg = TAP_COUNT_RST;
        decim_reg     = DECIMATION_RST;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_coef_load();
        test_reset_defaults();
        test_wrap();
        test_opcodes();
        test_reconfig_edges();
        test_backpressure();
        test_random_traffic(0, 0, 250);
        test_random_traffic(59, 0, 250);
        test_random_traffic(0, 59, 250);
        test_random_traffic(8, 8, 250);

        wait_quiet();
        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d outputs never arrived", expected_samples.size()));
        if (mismatch_count == 0)
            $display("fir_decimator_q15_core test passed");
        else
            $display("fir_decimator_q15_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/fdq15_pkg.sv
sv/fir_decimator_q15_core.sv
sv/fdq15_checker.sv
test/testbench.sv
